@@ src/mtile_pkg.sv @@
// mtile_pkg: types, constants and elaboration-time ROM builders for the
// lat/lon to Mercator tile pipeline. No dependencies.
`default_nettype none
package mtile_pkg;

	localparam int FX_W = 56;
	localparam int FRAC = 48;
	localparam int NCH = FX_W / 8;
	localparam int ROW_SH = FRAC + 1;
	localparam int COL_FRAC = 16;

	typedef logic signed [FX_W-1:0] fx_t;

	typedef struct packed {
		fx_t x;
		fx_t y;
		fx_t w;
	} vec_t;

	// sideband carried along the pipe with each word
	typedef struct packed {
		logic [4:0]  zoom;
		logic [15:0] col;
		logic        clamp;
		logic        row_fixed;
		logic        row_max;
		logic        d_neg;
		logic [5:0]  d;
	} side_t;

	localparam logic [21:0] COL_DIV = 22'd3515625;
	localparam logic [24:0] COL_RECIP = 25'((64'd1 << 46) / 64'd3515625);

	function automatic logic [63:0] calc_pi61();
		logic [63:0] pw;
		logic [63:0] sa;
		logic [63:0] sb;
		pw = (64'd1 << 61) / 64'd5;
		sa = '0;
		for (int k = 0; k < 32; k++) begin
			if (pw != 0) begin
				if (k[0])
					sa = sa - pw / 64'(2 * k + 1);
				else
					sa = sa + pw / 64'(2 * k + 1);
				pw = pw / 64'd25;
			end
		end
		pw = (64'd1 << 61) / 64'd239;
		sb = '0;
		for (int k = 0; k < 32; k++) begin
			if (pw != 0) begin
				if (k[0])
					sb = sb - pw / 64'(2 * k + 1);
				else
					sb = sb + pw / 64'(2 * k + 1);
				pw = pw / 64'd57121;
			end
		end
		return 64'd16 * sa - 64'd4 * sb;
	endfunction

	function automatic logic [63:0] calc_recip62(logic [63:0] p);
		logic [63:0] r;
		logic [63:0] q;
		r = 64'd1 << 61;
		q = '0;
		for (int i = 0; i < 62; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= p) begin
				r = r - p;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] round60to48(logic [63:0] v);
		return (v + (64'd1 << 11)) >> 12;
	endfunction

	function automatic logic [63:0] calc_ln2();
		logic [63:0] pw;
		logic [63:0] s;
		pw = (64'd1 << 60) / 64'd3;
		s = '0;
		for (int k = 0; k < 40; k++) begin
			if (pw != 0) begin
				s = s + pw / 64'(2 * k + 1);
				pw = pw / 64'd9;
			end
		end
		return round60to48(64'd2 * s);
	endfunction

	function automatic logic [63:0] series_pow2(int i, bit alt);
		logic [63:0] s;
		logic [63:0] term;
		int e;
		s = '0;
		for (int k = 0; k < 31; k++) begin
			e = i * (2 * k + 1);
			if (e <= 60) begin
				term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
				if (alt && k[0])
					s = s - term;
				else
					s = s + term;
			end
		end
		return s;
	endfunction

	localparam logic [63:0] PI61 = calc_pi61();
	localparam logic [61:0] INV_PI62 = 62'(calc_recip62(PI61));
	localparam logic [63:0] QPI64 = (PI61 + (64'd1 << 14)) >> 15;
	localparam logic [33:0] HALF_RAD_K = 34'(PI61 / 64'd450000000);
	localparam logic [47:0] LN2 = 48'(calc_ln2());
	localparam fx_t QPI = fx_t'(QPI64);
	localparam fx_t FX_ONE = fx_t'(64'd1 << FRAC);

	function automatic logic [63:0] atan_val(int i);
		if (i == 0)
			return QPI64;
		return round60to48(series_pow2(i, 1'b1));
	endfunction

	function automatic logic [63:0] atanh_val(int i);
		return round60to48(series_pow2(i, 1'b0));
	endfunction

	function automatic vec_t circ_step(vec_t v, int sh, fx_t a);
		fx_t x;
		fx_t y;
		fx_t w;
		fx_t dx;
		fx_t dy;
		vec_t r;
		x = v.x;
		y = v.y;
		w = v.w;
		dx = y >>> sh;
		dy = x >>> sh;
		if (w >= 0) begin
			r.x = x - dx;
			r.y = y + dy;
			r.w = w - a;
		end else begin
			r.x = x + dx;
			r.y = y - dy;
			r.w = w + a;
		end
		return r;
	endfunction

	function automatic vec_t hyp_step(vec_t v, int sh, fx_t a);
		fx_t x;
		fx_t y;
		fx_t w;
		fx_t dx;
		fx_t dy;
		vec_t r;
		x = v.x;
		y = v.y;
		w = v.w;
		dx = y >>> sh;
		dy = x >>> sh;
		if (y >= 0) begin
			r.x = x - dx;
			r.y = y - dy;
			r.w = w + a;
		end else begin
			r.x = x + dx;
			r.y = y + dy;
			r.w = w - a;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/mtile_circ.sv @@
// mtile_circ: rotation-mode circular CORDIC, one stage per register.
// Depends on mtile_pkg.
`default_nettype none
module mtile_circ #(
	parameter int N = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire mtile_pkg::fx_t   in_w,
	input  wire mtile_pkg::side_t in_side,
	output logic                  out_valid,
	output mtile_pkg::vec_t       out_vec,
	output mtile_pkg::side_t      out_side
);

	logic             v_s  [0:N];
	mtile_pkg::vec_t  c_s  [0:N];
	mtile_pkg::side_t sd_s [0:N];

	always_comb begin
		v_s[0] = in_valid;
		c_s[0].x = mtile_pkg::FX_ONE;
		c_s[0].y = '0;
		c_s[0].w = in_w;
		sd_s[0] = in_side;
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		localparam mtile_pkg::fx_t ANG = mtile_pkg::fx_t'(mtile_pkg::atan_val(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else
				v_s[i+1] <= v_s[i];
		end
		always_ff @(posedge clk) begin
			c_s[i+1] <= mtile_pkg::circ_step(c_s[i], i, ANG);
			sd_s[i+1] <= sd_s[i];
		end
	end

	assign out_valid = v_s[N];
	assign out_vec = c_s[N];
	assign out_side = sd_s[N];

endmodule
`default_nettype wire

@@ src/mtile_hyp.sv @@
// mtile_hyp: operand alignment and vectoring-mode hyperbolic CORDIC (half ln of y/x).
// Depends on mtile_pkg.
`default_nettype none
module mtile_hyp #(
	parameter int N = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire mtile_pkg::vec_t  in_vec,
	input  wire mtile_pkg::side_t in_side,
	output logic                  out_valid,
	output mtile_pkg::fx_t        out_w,
	output mtile_pkg::side_t      out_side
);

	localparam int NCH = mtile_pkg::NCH;
	localparam int FW = mtile_pkg::FX_W;

	// leading-one search, split: per-byte flags, then byte select
	logic [NCH-1:0]      snz;
	logic [NCH-1:0]      cnz;
	logic [NCH-1:0][2:0] spos;
	logic [NCH-1:0][2:0] cpos;
	mtile_pkg::side_t    sd0;

	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			snz[ch] = |in_vec.y[8*ch +: 8];
			cnz[ch] = |in_vec.x[8*ch +: 8];
			spos[ch] = '0;
			cpos[ch] = '0;
			for (int b = 0; b < 8; b++) begin
				if (in_vec.y[8*ch + b])
					spos[ch] = 3'(b);
				if (in_vec.x[8*ch + b])
					cpos[ch] = 3'(b);
			end
		end
		sd0 = in_side;
		if (!in_side.row_fixed) begin
			if (in_vec.x <= 0) begin
				sd0.row_fixed = 1'b1;
				sd0.row_max = 1'b0;
				sd0.clamp = 1'b1;
			end else if (in_vec.y <= 0) begin
				sd0.row_fixed = 1'b1;
				sd0.row_max = 1'b1;
				sd0.clamp = 1'b1;
			end
		end
	end

	logic                v_s1;
	logic [FW-1:0]       s_s1;
	logic [FW-1:0]       c_s1;
	logic [NCH-1:0]      snz_s1;
	logic [NCH-1:0]      cnz_s1;
	logic [NCH-1:0][2:0] spos_s1;
	logic [NCH-1:0][2:0] cpos_s1;
	mtile_pkg::side_t    sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		s_s1 <= in_vec.y;
		c_s1 <= in_vec.x;
		snz_s1 <= snz;
		cnz_s1 <= cnz;
		spos_s1 <= spos;
		cpos_s1 <= cpos;
		sd_s1 <= sd0;
	end

	logic [5:0]       ms;
	logic [5:0]       mc;
	mtile_pkg::side_t sd1;

	always_comb begin
		ms = '0;
		mc = '0;
		for (int ch = 0; ch < NCH; ch++) begin
			if (snz_s1[ch])
				ms = {3'(ch), spos_s1[ch]};
			if (cnz_s1[ch])
				mc = {3'(ch), cpos_s1[ch]};
		end
		sd1 = sd_s1;
		sd1.d_neg = ms < mc;
		sd1.d = (ms >= mc) ? (ms - mc) : (mc - ms);
	end

	logic             v_s2;
	logic [FW-1:0]    s_s2;
	logic [FW-1:0]    c_s2;
	mtile_pkg::side_t sd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		s_s2 <= s_s1;
		c_s2 <= c_s1;
		sd_s2 <= sd1;
	end

	logic [FW-1:0] s_al;
	logic [FW-1:0] c_al;

	always_comb begin
		s_al = s_s2;
		c_al = c_s2;
		if (sd_s2.d_neg)
			s_al = s_s2 << sd_s2.d;
		else
			c_al = c_s2 << sd_s2.d;
	end

	logic             v_s  [0:N];
	mtile_pkg::vec_t  h_s  [0:N];
	mtile_pkg::side_t sd_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else
			v_s[0] <= v_s2;
	end
	always_ff @(posedge clk) begin
		h_s[0].x <= s_al + c_al;
		h_s[0].y <= s_al - c_al;
		h_s[0].w <= '0;
		sd_s[0] <= sd_s2;
	end

	for (genvar i = 1; i <= N; i++) begin : g_st
		localparam mtile_pkg::fx_t ANG = mtile_pkg::fx_t'(mtile_pkg::atanh_val(i));
		if (i == 4 || i == 13 || i == 40) begin : g_rep
			logic             mv_q;
			mtile_pkg::vec_t  mh_q;
			mtile_pkg::side_t msd_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mv_q <= 1'b0;
					v_s[i] <= 1'b0;
				end else begin
					mv_q <= v_s[i-1];
					v_s[i] <= mv_q;
				end
			end
			always_ff @(posedge clk) begin
				mh_q <= mtile_pkg::hyp_step(h_s[i-1], i, ANG);
				msd_q <= sd_s[i-1];
				h_s[i] <= mtile_pkg::hyp_step(mh_q, i, ANG);
				sd_s[i] <= msd_q;
			end
		end else begin : g_one
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					v_s[i] <= 1'b0;
				else
					v_s[i] <= v_s[i-1];
			end
			always_ff @(posedge clk) begin
				h_s[i] <= mtile_pkg::hyp_step(h_s[i-1], i, ANG);
				sd_s[i] <= sd_s[i-1];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_w = h_s[N].w;
	assign out_side = sd_s[N];

endmodule
`default_nettype wire

@@ src/latlon_to_mercator_tile.sv @@
// latlon_to_mercator_tile: top level; column divider, latitude prep, ln/pi tail.
// Depends on mtile_pkg, mtile_circ, mtile_hyp.
//
// channel  signals                               dir  notes
// cmd      start, busy, lat_e7, lon_e7           in   busy is always low
// result   done, tile_code, clamped              out  one-cycle strobe
// cfg      cfg_valid, cfg_ready, zoom_level      in   ready always high
//
// One word may enter every cycle. done follows start through s1 to s3, the
// circular CORDIC chain, the hyperbolic alignment and CORDIC chain (stages
// 4, 13 and 40 repeated where they fall within CORDIC_STAGES), s4 to s7 and
// the output register; the two unrolled CORDIC chains make up most of it. Reset clears the valid
// bits and sets zoom to 11. The receiver cannot stall, so nothing holds.
`default_nettype none
module latlon_to_mercator_tile #(
	parameter int CORDIC_STAGES = 32,
	parameter int MAX_ZOOM = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [30:0] lat_e7,
	input  wire logic signed [31:0] lon_e7,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [4:0]         zoom_level,
	output logic                    done,
	output logic [31:0]             tile_code,
	output logic                    clamped
);

	localparam int FW = mtile_pkg::FX_W;

	logic [4:0] zoom_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			zoom_q <= 5'd11;
		else if (cfg_valid && cfg_ready)
			zoom_q <= zoom_level;
	end

	// s1: capture
	logic               v_s1;
	logic signed [30:0] lat_s1;
	logic signed [32:0] n_s1;
	logic [4:0]         z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start && !busy;
	end
	always_ff @(posedge clk) begin
		lat_s1 <= lat_e7;
		n_s1 <= $signed({lon_e7[31], lon_e7}) + 33'sd1800000000;
		z_s1 <= (zoom_q > 5'(MAX_ZOOM)) ? 5'(MAX_ZOOM) : zoom_q;
	end

	// s2: reciprocal estimate for the column, lat * deg-to-rad
	logic [29:0] mag;
	assign mag = lat_s1[30] ? 30'(-lat_s1) : lat_s1[29:0];

	logic        v_s2;
	logic [16:0] est_s2;
	logic [31:0] n_s2;
	logic        nneg_s2;
	logic [63:0] hp_s2;
	logic        latneg_s2;
	logic        lathi_s2;
	logic        latlo_s2;
	logic [4:0]  z_s2;
	logic [56:0] rprod;

	assign rprod = 57'(n_s1[31:0]) * 57'(mtile_pkg::COL_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		est_s2 <= rprod[56:40];
		n_s2 <= n_s1[31:0];
		nneg_s2 <= n_s1[32];
		hp_s2 <= 64'(mag) * 64'(mtile_pkg::HALF_RAD_K);
		latneg_s2 <= lat_s1[30];
		lathi_s2 <= lat_s1 >= 31'sd900000000;
		latlo_s2 <= lat_s1 <= -31'sd900000000;
		z_s2 <= z_s1;
	end

	// s3: column correction and clamp, CORDIC angle
	logic [38:0]      rem;
	logic [16:0]      q;
	logic [16:0]      colf;
	logic [15:0]      maxidx2;
	logic [47:0]      hh;
	mtile_pkg::side_t sd2;

	always_comb begin
		rem = 39'({n_s2, 6'b0}) - 39'(est_s2) * 39'(mtile_pkg::COL_DIV);
		q = est_s2 + 17'(rem >= 39'(mtile_pkg::COL_DIV));
		colf = q >> (5'(mtile_pkg::COL_FRAC) - z_s2);
		maxidx2 = 16'((17'd1 << z_s2) - 17'd1);
		hh = 48'((hp_s2 + (64'd1 << 15)) >> 16);
		sd2 = '0;
		sd2.zoom = z_s2;
		if (nneg_s2) begin
			sd2.col = '0;
			sd2.clamp = 1'b1;
		end else if (colf > 17'(maxidx2)) begin
			sd2.col = maxidx2;
			sd2.clamp = 1'b1;
		end else begin
			sd2.col = colf[15:0];
		end
		if (lathi_s2) begin
			sd2.row_fixed = 1'b1;
			sd2.clamp = 1'b1;
		end else if (latlo_s2) begin
			sd2.row_fixed = 1'b1;
			sd2.row_max = 1'b1;
			sd2.clamp = 1'b1;
		end
	end

	logic             v_s3;
	mtile_pkg::fx_t   w_s3;
	mtile_pkg::side_t sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		w_s3 <= latneg_s2 ? (mtile_pkg::QPI - mtile_pkg::fx_t'(hh))
			: (mtile_pkg::QPI + mtile_pkg::fx_t'(hh));
		sd_s3 <= sd2;
	end

	logic             cv;
	mtile_pkg::vec_t  cvec;
	mtile_pkg::side_t csd;

	mtile_circ #(.N(CORDIC_STAGES)) u_circ (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.in_w     (w_s3),
		.in_side  (sd_s3),
		.out_valid(cv),
		.out_vec  (cvec),
		.out_side (csd)
	);

	logic             hv;
	mtile_pkg::fx_t   hw;
	mtile_pkg::side_t hsd;

	mtile_hyp #(.N(CORDIC_STAGES)) u_hyp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv),
		.in_vec   (cvec),
		.in_side  (csd),
		.out_valid(hv),
		.out_w    (hw),
		.out_side (hsd)
	);

	// s4: m = 2*w +/- d*ln2
	logic [53:0]    dl;
	mtile_pkg::fx_t dls;
	assign dl = 54'(hsd.d) * 54'(mtile_pkg::LN2);
	assign dls = mtile_pkg::fx_t'({2'b00, dl});

	logic             v_s4;
	mtile_pkg::fx_t   m_s4;
	mtile_pkg::side_t sd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= hv;
	end
	always_ff @(posedge clk) begin
		m_s4 <= (hw <<< 1) + (hsd.d_neg ? -dls : dls);
		sd_s4 <= hsd;
	end

	// s5: |m| * (1/pi) as four partial products
	logic [FW-1:0] mm;
	assign mm = m_s4[FW-1] ? FW'(-m_s4) : FW'(m_s4);

	logic             v_s5;
	logic             mneg_s5;
	logic [63:0]      ll_s5;
	logic [55:0]      hl_s5;
	logic [61:0]      lh_s5;
	logic [53:0]      hh_s5;
	mtile_pkg::side_t sd_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else
			v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		mneg_s5 <= m_s4[FW-1];
		ll_s5 <= 64'(mm[31:0]) * 64'(mtile_pkg::INV_PI62[31:0]);
		hl_s5 <= 56'(mm[55:32]) * 56'(mtile_pkg::INV_PI62[31:0]);
		lh_s5 <= 62'(mm[31:0]) * 62'(mtile_pkg::INV_PI62[61:32]);
		hh_s5 <= 54'(mm[55:32]) * 54'(mtile_pkg::INV_PI62[61:32]);
		sd_s5 <= sd_s4;
	end

	// s6: middle column sum
	logic             v_s6;
	logic             mneg_s6;
	logic [63:0]      mid_s6;
	logic [53:0]      hh_s6;
	mtile_pkg::side_t sd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else
			v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		mneg_s6 <= mneg_s5;
		mid_s6 <= 64'(hl_s5) + 64'(lh_s5) + 64'(ll_s5[63:32]);
		hh_s6 <= hh_s5;
		sd_s6 <= sd_s5;
	end

	// s7: u = 1 -/+ m/pi
	logic [85:0] full;
	logic [55:0] vq;
	assign full = {hh_s6, 32'b0} + 86'(mid_s6);
	assign vq = full[85:30];

	logic               v_s7;
	logic signed [57:0] u_s7;
	mtile_pkg::side_t   sd_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else
			v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		u_s7 <= mneg_s6 ? (58'sd1 <<< mtile_pkg::FRAC) + $signed({2'b00, vq})
			: (58'sd1 <<< mtile_pkg::FRAC) - $signed({2'b00, vq});
		sd_s7 <= sd_s6;
	end

	// output: row select, pack
	logic [56:0] rowsh;
	logic [15:0] maxidx7;
	logic [15:0] row;
	logic        rclamp;

	always_comb begin
		rowsh = u_s7[56:0] >> (6'(mtile_pkg::ROW_SH) - 6'(sd_s7.zoom));
		maxidx7 = 16'((17'd1 << sd_s7.zoom) - 17'd1);
		rclamp = sd_s7.clamp;
		if (sd_s7.row_fixed) begin
			row = sd_s7.row_max ? maxidx7 : '0;
		end else if (u_s7 < 0) begin
			row = '0;
			rclamp = 1'b1;
		end else if (rowsh > 57'(maxidx7)) begin
			row = maxidx7;
			rclamp = 1'b1;
		end else begin
			row = rowsh[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= v_s7;
	end
	always_ff @(posedge clk) begin
		tile_code <= (32'(sd_s7.col) << sd_s7.zoom) | 32'(row);
		clamped <= rclamp;
	end

	a_zoom_cap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> z_s1 <= 5'(MAX_ZOOM))
		else $error("zoom above cap in pipe");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> 17'(sd_s3.col) <= ((17'd1 << sd_s3.zoom) - 17'd1))
		else $error("column beyond grid");

	a_fix_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && sd_s7.row_fixed |-> sd_s7.clamp)
		else $error("forced row without clamp flag");

	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s7))
		else $error("result strobe without word");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for latlon_to_mercator_tile: directed and random points checked
// against a fixed-point tile predictor held here. Needs only the RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [30:0] lat_e7;
	logic signed [31:0] lon_e7;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [4:0]         zoom_level;
	logic               done;
	logic [31:0]        tile_code;
	logic               clamped;

	localparam int STAGES = 32;
	localparam int ZOOM_CAP = 16;
	localparam int WD_LIMIT = 4000;
	localparam int LAT_LIM = 900000000;

	typedef struct {
		logic [31:0] code;
		logic        clamp;
	} tile_t;

	tile_t       tiles_due[$];
	int          errors;
	int          stall_cycles;
	bit          quiet;
	logic [4:0]  zoom_now;
	longint      atan_k[STAGES+1];
	longint      atanh_k[STAGES+1];
	longint      ln2_k;
	longint      qpi_k;
	logic [63:0] halfrad_k;
	logic [63:0] invpi_k;

	latlon_to_mercator_tile dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.lat_e7(lat_e7), .lon_e7(lon_e7), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .zoom_level(zoom_level), .done(done),
		.tile_code(tile_code), .clamped(clamped)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] arctan_inv(logic [63:0] n, int fb, bit alt);
		logic [63:0] pw;
		logic [63:0] acc;
		pw = (64'd1 << fb) / n;
		acc = 0;
		for (int k = 0; pw != 0; k++) begin
			if (alt && k[0]) acc = acc - pw / (2 * k + 1);
			else acc = acc + pw / (2 * k + 1);
			pw = pw / (n * n);
		end
		return acc;
	endfunction

	function automatic logic [63:0] arctan_pow2(int i, bit alt);
		logic [63:0] acc;
		acc = 0;
		for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
			if (alt && k[0]) acc = acc - (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
			else acc = acc + (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
		end
		return acc;
	endfunction

	function automatic longint to48(logic [63:0] v);
		return longint'((v + 64'd2048) >> 12);
	endfunction

	function automatic void build_constants();
		logic [63:0] pi61;
		logic [63:0] r;
		logic [63:0] q;
		pi61 = 16 * arctan_inv(5, 61, 1) - 4 * arctan_inv(239, 61, 1);
		r = 64'd1 << 61;
		q = 0;
		for (int i = 0; i < 62; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= pi61) begin
				r = r - pi61;
				q = q | 1;
			end
		end
		invpi_k = q;
		qpi_k = longint'((pi61 + (64'd1 << 14)) >> 15);
		halfrad_k = pi61 / 64'd450000000;
		ln2_k = to48(2 * arctan_inv(3, 60, 0));
		atan_k[0] = qpi_k;
		atanh_k[0] = 0;
		for (int i = 1; i <= STAGES; i++) begin
			atan_k[i] = to48(arctan_pow2(i, 1));
			atanh_k[i] = to48(arctan_pow2(i, 0));
		end
	endfunction

	function automatic int top_bit(logic [63:0] v);
		int p;
		p = 0;
		while (v > 1) begin
			v = v >> 1;
			p++;
		end
		return p;
	endfunction

	function automatic void hyp_rot(inout longint x, inout longint y, inout longint w, input int i);
		longint dx;
		longint dy;
		dx = y >>> i;
		dy = x >>> i;
		if (y >= 0) begin
			x = x - dx; y = y - dy; w = w + atanh_k[i];
		end else begin
			x = x + dx; y = y + dy; w = w - atanh_k[i];
		end
	endfunction

	function automatic tile_t tile_of(logic [4:0] zreg, logic signed [30:0] la,
			logic signed [31:0] lo);
		tile_t t;
		int z;
		int ms;
		int mc;
		int d;
		int rep;
		logic [63:0] maxidx;
		logic [63:0] col;
		logic [63:0] row;
		logic [63:0] mag;
		logic [63:0] s;
		logic [63:0] c;
		logic [63:0] mm;
		logic [63:0] v;
		logic [127:0] prod;
		longint lat;
		longint n;
		longint h;
		longint x;
		longint y;
		longint w;
		longint dx;
		longint dy;
		longint hx;
		longint hy;
		longint hw;
		longint m;
		longint u;
		z = zreg > ZOOM_CAP ? ZOOM_CAP : zreg;
		maxidx = (64'd1 << z) - 1;
		lat = la;
		n = longint'(lo) + 1800000000;
		t.clamp = 0;
		if (n < 0) begin
			col = 0; t.clamp = 1;
		end else begin
			col = (64'(n) << z) / 64'd3600000000;
			if (col > maxidx) begin
				col = maxidx; t.clamp = 1;
			end
		end
		if (lat >= LAT_LIM) begin
			row = 0; t.clamp = 1;
		end else if (lat <= -LAT_LIM) begin
			row = maxidx; t.clamp = 1;
		end else begin
			mag = 64'(lat < 0 ? -lat : lat);
			h = longint'((mag * halfrad_k + (64'd1 << 15)) >> 16);
			x = 64'd1 << 48;
			y = 0;
			w = lat < 0 ? qpi_k - h : qpi_k + h;
			for (int i = 0; i < STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (w >= 0) begin
					x = x - dx; y = y + dy; w = w - atan_k[i];
				end else begin
					x = x + dx; y = y - dy; w = w + atan_k[i];
				end
			end
			if (x <= 0) begin
				row = 0; t.clamp = 1;
			end else if (y <= 0) begin
				row = maxidx; t.clamp = 1;
			end else begin
				s = y;
				c = x;
				ms = top_bit(s);
				mc = top_bit(c);
				if (ms >= mc) begin
					d = ms - mc; c = c << d;
				end else begin
					d = mc - ms; s = s << d;
				end
				hx = longint'(s + c);
				hy = longint'(s) - longint'(c);
				hw = 0;
				rep = 4;
				for (int i = 1; i <= STAGES; i++) begin
					hyp_rot(hx, hy, hw, i);
					if (i == rep) begin
						hyp_rot(hx, hy, hw, i);
						rep = 3 * rep + 1;
					end
				end
				m = 2 * hw + (ms >= mc ? longint'(d) * ln2_k : -longint'(d) * ln2_k);
				mm = 64'(m < 0 ? -m : m);
				prod = {64'd0, mm} * {64'd0, invpi_k};
				v = 64'(prod >> 62);
				u = m < 0 ? (longint'(1) << 48) + longint'(v) : (longint'(1) << 48) - longint'(v);
				if (u < 0) begin
					row = 0; t.clamp = 1;
				end else begin
					row = 64'(u) >> (49 - z);
					if (row > maxidx) begin
						row = maxidx; t.clamp = 1;
					end
				end
			end
		end
		t.code = 32'((col << z) | row);
		return t;
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		tile_t e;
		if (arst_n) begin
			if ((start && !busy) || done) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WD_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
		if (done) begin
			if (tiles_due.size() == 0) begin
				$error("unexpected result word: tile_code %h clamped %b", tile_code, clamped);
				errors++;
			end else begin
				e = tiles_due.pop_front();
				if (tile_code !== e.code) begin
					$error("tile_code: expected %h, actual %h", e.code, tile_code);
					errors++;
				end
				if (clamped !== e.clamp) begin
					$error("clamped: expected %b, actual %b", e.clamp, clamped);
					errors++;
				end
			end
		end
	end

	task automatic send_point(logic signed [30:0] la, logic signed [31:0] lo);
		int gap;
		start <= 1;
		lat_e7 <= la;
		lon_e7 <= lo;
		@(posedge clk);
		while (busy) @(posedge clk);
		tiles_due.push_back(tile_of(zoom_now, la, lo));
		if (!quiet && $urandom_range(99) < 25) begin
			start <= 0;
			gap = $urandom_range(1, 2);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic set_zoom(logic [4:0] zv);
		start <= 0;
		@(posedge clk);
		while (tiles_due.size() != 0) @(posedge clk);
		cfg_valid <= 1;
		zoom_level <= zv;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		zoom_now = zv;
	endtask

	task automatic test_directed_points();
		logic signed [30:0] lats[10];
		logic signed [31:0] lons[6];
		lats = '{0, 900000000, -900000000, 850511287, -850511287, 850511288,
			-850511288, 31'sh3FFFFFFF, 31'sh40000000, 1};
		lons = '{-1800000000, 1800000000, 0, 1799999999, 32'sh7FFFFFFF, 32'sh80000000};
		for (int i = 0; i < 10; i++)
			send_point(lats[i], lons[i % 6]);
		for (int i = 0; i < 6; i++)
			send_point(31'($urandom_range(0, 1700000000)) - 31'sd850000000, lons[i]);
	endtask

	task automatic test_zoom_extremes();
		logic [4:0] zs[5];
		zs = '{5'd0, 5'd16, 5'd17, 5'd31, 5'd1};
		foreach (zs[k]) begin
			set_zoom(zs[k]);
			test_directed_points();
		end
	endtask

	function automatic logic signed [30:0] pick_lat();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 31'($urandom_range(0, 1800000000)) - 31'sd900000000;
		if (r < 80) return ($urandom_range(1) ? 31'sd1 : -31'sd1) *
			31'($urandom_range(850400000, 850600000));
		return 31'($urandom);
	endfunction

	function automatic logic signed [31:0] pick_lon();
		if ($urandom_range(99) < 85)
			return 32'($urandom_range(0, 32'd3600000000)) - 32'sd1800000000;
		return 32'($urandom);
	endfunction

	task automatic test_random_points();
		logic [4:0] zs[8];
		zs = '{5'd3, 5'd16, 5'd8, 5'd0, 5'd12, 5'd20, 5'd11, 5'd16};
		foreach (zs[k]) begin
			set_zoom(zs[k]);
			quiet = (k == 3);
			repeat (82) send_point(pick_lat(), pick_lon());
		end
		quiet = 0;
	endtask

	initial begin
		errors = 0;
		stall_cycles = 0;
		quiet = 0;
		zoom_now = 5'd11;
		build_constants();
		arst_n = 0;
		start = 0;
		lat_e7 = 0;
		lon_e7 = 0;
		cfg_valid = 0;
		zoom_level = 5'd11;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed_points();
		test_zoom_extremes();
		test_random_points();
		start <= 0;
		while (tiles_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ latlon_to_mercator_tile.f @@
src/mtile_pkg.sv
src/mtile_circ.sv
src/mtile_hyp.sv
src/latlon_to_mercator_tile.sv
tb/testbench.sv
